// File: src/atpc_pkg.sv
// shared constants, command codes and types of the box table collision block
package atpc_pkg;

	localparam int MAX_BOXES   = 64;
	localparam int FRAC_BITS   = 8;
	localparam int COORD_W     = 16;
	localparam int MARGIN_W    = 15;
	localparam int WIDE_W      = COORD_W + 2;
	localparam int CNT_W       = $clog2(MAX_BOXES + 1);
	localparam int COUNT_OUT_W = 7;

	// 0.03 rounded to the nearest fixed point step
	localparam logic [MARGIN_W-1:0] MARGIN_RESET =
		MARGIN_W'((3 * (1 << FRAC_BITS) + 50) / 100);

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_START  = 3'd1,
		CMD_VERTEX = 3'd2,
		CMD_COMMIT = 3'd3,
		CMD_QUERY  = 3'd4
	} cmd_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;

	typedef struct packed {
		coord_t min_x;
		coord_t max_x;
		coord_t min_z;
		coord_t max_z;
	} box_t;

	// query point widened by the margin, travelling down the cell row
	typedef struct packed {
		logic  valid;
		logic  hit;
		wide_t x_lo;
		wide_t x_hi;
		wide_t z_lo;
		wide_t z_hi;
	} probe_t;

endpackage

// File: src/atpc_cell.sv
// one cell of the box row: holds one stored box and tests the passing probe
module atpc_cell import atpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  logic   active,
	input  box_t   box_in,
	output box_t   box_out,
	input  probe_t probe_in,
	output probe_t probe_out
);

	box_t   box_q;
	probe_t probe_q;
	probe_t probe_next;
	logic   touch;

	// inclusive overlap of the widened point and the held box
	assign touch = (probe_in.x_hi >= wide_t'(box_q.min_x)) &&
	               (wide_t'(box_q.max_x) >= probe_in.x_lo) &&
	               (probe_in.z_hi >= wide_t'(box_q.min_z)) &&
	               (wide_t'(box_q.max_z) >= probe_in.z_lo);

	// probe handed on with this cell's hit folded in
	always_comb begin
		probe_next     = probe_in;
		probe_next.hit = probe_in.hit | (probe_in.valid & active & touch);
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			box_q <= box_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_next;
		end
	end

	assign box_out   = box_q;
	assign probe_out = probe_q;

endmodule

// File: src/aabb_table_point_collision.sv
// top level of the box table collision block: command decode, box row, result register
//
//  channel  direction  handshake                  payload
//  in       to block   in_valid / in_stall        command, coord_x, coord_z
//  out      from block out_valid / out_stall      hit, box_count, table_full, scene_*
//  cfg      to block   cfg_valid / cfg_ready      cfg_data (margin)
//
// clear, start, vertex, commit and unused codes: result registered in the cycle after the transaction
// a query runs a probe through the row of MAX_BOXES cells, one cell a cycle, and the input
//   stays stalled until the query's result is loaded
// arst_n clears all control state, the working box and scene bounds; the stored boxes are not
//   cleared, only cells below the box count take part in a query
// a stalled result holds; the next transaction is taken while the last result drains
module aabb_table_point_collision import atpc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// input transactions
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 command,
	input  logic signed [COORD_W-1:0]  coord_x,
	input  logic signed [COORD_W-1:0]  coord_z,
	// result transactions
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic [COUNT_OUT_W-1:0]     box_count,
	output logic                       table_full,
	output logic signed [COORD_W-1:0]  scene_min_x,
	output logic signed [COORD_W-1:0]  scene_max_x,
	output logic signed [COORD_W-1:0]  scene_min_z,
	output logic signed [COORD_W-1:0]  scene_max_z,
	// margin register write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [MARGIN_W-1:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	function automatic coord_t cmin(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic coord_t cmax(input coord_t a, input coord_t b);
		return (a > b) ? a : b;
	endfunction

	state_t               state_q;
	box_t                 working_q;
	box_t                 scene_q;
	logic                 fresh_q;
	logic [CNT_W-1:0]     count_q;
	logic [MARGIN_W-1:0]  margin_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic                 full_q;
	logic                 hold_hit_q;

	logic                 out_free;
	logic                 in_accept;
	logic                 is_full;
	logic                 shift_en;
	logic                 scan_done;
	box_t                 widened;
	box_t                 merged;
	wide_t                px_w;
	wide_t                pz_w;
	wide_t                m_w;
	probe_t               probe_head;

	logic                 active   [MAX_BOXES];
	box_t                 box_link [MAX_BOXES+1];
	probe_t               probe_link [MAX_BOXES+1];

	// handshakes
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign is_full  = (count_q == CNT_W'(MAX_BOXES));
	assign shift_en = in_accept && (command == CMD_COMMIT) && !is_full;

	// vertex widening of the working box
	assign widened.min_x = cmin(working_q.min_x, coord_x);
	assign widened.max_x = cmax(working_q.max_x, coord_x);
	assign widened.min_z = cmin(working_q.min_z, coord_z);
	assign widened.max_z = cmax(working_q.max_z, coord_z);

	// scene bounds folded with the box being committed
	assign merged.min_x = cmin(scene_q.min_x, working_q.min_x);
	assign merged.max_x = cmax(scene_q.max_x, working_q.max_x);
	assign merged.min_z = cmin(scene_q.min_z, working_q.min_z);
	assign merged.max_z = cmax(scene_q.max_z, working_q.max_z);

	// query point widened by the margin, two guard bits so nothing wraps
	assign px_w = wide_t'(coord_x);
	assign pz_w = wide_t'(coord_z);
	assign m_w  = wide_t'(margin_q);

	assign probe_head.valid = in_accept && (command == CMD_QUERY);
	assign probe_head.hit   = 1'b0;
	assign probe_head.x_lo  = px_w - m_w;
	assign probe_head.x_hi  = px_w + m_w;
	assign probe_head.z_lo  = pz_w - m_w;
	assign probe_head.z_hi  = pz_w + m_w;

	// new boxes enter at the head and every stored box moves one cell on
	assign box_link[0]   = working_q;
	assign probe_link[0] = probe_head;

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_row
		assign active[i] = (count_q > CNT_W'(i));

		atpc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (shift_en),
			.active    (active[i]),
			.box_in    (box_link[i]),
			.box_out   (box_link[i+1]),
			.probe_in  (probe_link[i]),
			.probe_out (probe_link[i+1])
		);
	end

	assign scan_done = (state_q == ST_SCAN) && probe_link[MAX_BOXES].valid;

	// table state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			working_q  <= '0;
			scene_q    <= '0;
			fresh_q    <= 1'b1;
			count_q    <= '0;
			margin_q   <= MARGIN_RESET;
			hold_hit_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				margin_q <= cfg_data;
			end

			if (in_accept) begin
				case (command)
					CMD_CLEAR: begin
						count_q   <= '0;
						scene_q   <= '0;
						working_q <= '0;
						fresh_q   <= 1'b1;
					end
					CMD_START: begin
						fresh_q <= 1'b1;
					end
					CMD_VERTEX: begin
						if (fresh_q) begin
							working_q <= '{min_x: coord_x, max_x: coord_x,
							               min_z: coord_z, max_z: coord_z};
						end else begin
							working_q <= widened;
						end
						fresh_q <= 1'b0;
					end
					CMD_COMMIT: begin
						if (!is_full) begin
							count_q <= count_q + CNT_W'(1);
							scene_q <= (count_q == '0) ? working_q : merged;
						end
					end
					CMD_QUERY: begin
						state_q <= ST_SCAN;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_SCAN: begin
					if (probe_link[MAX_BOXES].valid) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							hold_hit_q <= probe_link[MAX_BOXES].hit;
							state_q    <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (in_accept && (command != CMD_QUERY)) begin
				out_valid_q <= 1'b1;
				hit_q       <= 1'b0;
				full_q      <= (command == CMD_COMMIT) && is_full;
			end else if (scan_done && out_free) begin
				out_valid_q <= 1'b1;
				hit_q       <= probe_link[MAX_BOXES].hit;
				full_q      <= 1'b0;
			end else if ((state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
				hit_q       <= hold_hit_q;
				full_q      <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// count and bounds only change when a new result is loaded
	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign table_full  = full_q;
	assign box_count   = COUNT_OUT_W'(count_q);
	assign scene_min_x = scene_q.min_x;
	assign scene_max_x = scene_q.max_x;
	assign scene_min_z = scene_q.min_z;
	assign scene_max_z = scene_q.max_z;

endmodule

// File: bench/aabb_table_point_collision_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the box table collision block: directed and random command streams
module aabb_table_point_collision_tb import atpc_pkg::*; ();

	typedef struct packed {
		logic                   hit;
		logic [COUNT_OUT_W-1:0] box_count;
		logic                   table_full;
		coord_t                 min_x;
		coord_t                 max_x;
		coord_t                 min_z;
		coord_t                 max_z;
	} status_t;

	// keeps its own copy of the box table and the scene bounds, one status per command
	class table_scoreboard;
		int      margin = MARGIN_RESET;
		box_t    boxes[$];
		box_t    working = '0;
		logic    fresh = 1'b1;
		box_t    scene = '0;
		status_t pending_status[$];
		int      errors = 0;
		int      queries = 0;
		int      hits = 0;
		int      drops = 0;
		int      commits = 0;

		function bit touches(box_t b, int px, int pz);
			return (px + margin >= int'(b.min_x)) && (int'(b.max_x) >= px - margin) &&
				(pz + margin >= int'(b.min_z)) && (int'(b.max_z) >= pz - margin);
		endfunction

		function void note_command(logic [2:0] cmd, coord_t x, coord_t z);
			status_t s;
			s = '0;
			case (cmd)
			CMD_CLEAR: begin
				boxes.delete();
				scene   = '0;
				working = '0;
				fresh   = 1'b1;
			end
			CMD_START: fresh = 1'b1;
			CMD_VERTEX: begin
				if (fresh) begin
					working.min_x = x;
					working.max_x = x;
					working.min_z = z;
					working.max_z = z;
					fresh = 1'b0;
				end else begin
					if (x < working.min_x) working.min_x = x;
					if (x > working.max_x) working.max_x = x;
					if (z < working.min_z) working.min_z = z;
					if (z > working.max_z) working.max_z = z;
				end
			end
			CMD_COMMIT: begin
				if (boxes.size() >= MAX_BOXES) begin
					s.table_full = 1'b1;
					drops++;
				end else begin
					if (boxes.size() == 0) begin
						scene = working;
					end else begin
						if (working.min_x < scene.min_x) scene.min_x = working.min_x;
						if (working.max_x > scene.max_x) scene.max_x = working.max_x;
						if (working.min_z < scene.min_z) scene.min_z = working.min_z;
						if (working.max_z > scene.max_z) scene.max_z = working.max_z;
					end
					boxes = {boxes, working};
					commits++;
				end
			end
			CMD_QUERY: begin
				queries++;
				for (int i = 0; i < boxes.size(); i++) begin
					if (touches(boxes[i], x, z)) begin
						s.hit = 1'b1;
						break;
					end
				end
				if (s.hit) hits++;
			end
			default: ;
			endcase
			s.box_count = COUNT_OUT_W'(boxes.size());
			s.min_x = scene.min_x;
			s.max_x = scene.max_x;
			s.min_z = scene.min_z;
			s.max_z = scene.max_z;
			pending_status = {pending_status, s};
		endfunction

		function void compare(string name, logic signed [31:0] want,
			logic signed [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(status_t got);
			status_t want;
			if (pending_status.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = pending_status.pop_front();
			compare("hit", want.hit, got.hit);
			compare("box_count", want.box_count, got.box_count);
			compare("table_full", want.table_full, got.table_full);
			compare("scene_min_x", want.min_x, got.min_x);
			compare("scene_max_x", want.max_x, got.max_x);
			compare("scene_min_z", want.min_z, got.min_z);
			compare("scene_max_z", want.max_z, got.max_z);
		endfunction
	endclass

	localparam int GAP_PCT        = 8;
	localparam int PHASE_ITEMS    = 315;
	localparam int NUM_PHASES     = 6;
	// a query holds the input until its result is loaded, and result stalls hold it longer
	localparam int WATCHDOG_LIMIT = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [2:0]             command = CMD_CLEAR;
	coord_t                 coord_x = '0;
	coord_t                 coord_z = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   hit;
	logic [COUNT_OUT_W-1:0] box_count;
	logic                   table_full;
	coord_t                 scene_min_x;
	coord_t                 scene_max_x;
	coord_t                 scene_min_z;
	coord_t                 scene_max_z;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [MARGIN_W-1:0]    cfg_data = '0;

	// while set, neither side idles
	bit                     steady = 1'b0;
	int                     items_sent = 0;
	int                     idle_cycles = 0;
	table_scoreboard        sb = new();

	aabb_table_point_collision dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.coord_x     (coord_x),
		.coord_z     (coord_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.box_count   (box_count),
		.table_full  (table_full),
		.scene_min_x (scene_min_x),
		.scene_max_x (scene_max_x),
		.scene_min_z (scene_min_z),
		.scene_max_z (scene_max_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side backpressure, random except in the steady stretch
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < GAP_PCT);
	end

	// both transactions are sampled at the edge, before any driver update lands;
	// the result is checked first so a new command never pairs with an older result
	always @(posedge clk) begin : transaction_monitor
		status_t got;
		got = {hit, box_count, table_full, scene_min_x, scene_max_x, scene_min_z, scene_max_z};
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(got);
			if (in_valid && !in_stall)
				sb.note_command(command, coord_x, coord_z);
		end
	end

	// watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results still pending",
				$time, idle_cycles, sb.pending_status.size());
			$display("aabb_table_point_collision regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic bit take_gap();
		return !steady && ($urandom_range(0, 99) < GAP_PCT);
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return coord_t'(v);
	endfunction

	function automatic int spread(int s);
		return int'($urandom_range(0, 2 * s)) - s;
	endfunction

	function automatic coord_t any_coord();
		return coord_t'($urandom_range(0, 65535));
	endfunction

	// a point just inside or outside the widened edge, or somewhere across the box
	function automatic int near_edge(int lo, int hi, int m);
		case ($urandom_range(0, 2))
		0: return lo - m + spread(2);
		1: return hi + m + spread(2);
		default: return lo + int'($urandom_range(0, hi - lo));
		endcase
	endfunction

	// one input transaction; valid stays up between back-to-back commands
	task automatic send_item(input logic [2:0] cmd, input coord_t x, input coord_t z);
		if (take_gap()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (take_gap());
		end
		in_valid <= 1'b1;
		command  <= cmd;
		coord_x  <= x;
		coord_z  <= z;
		do @(posedge clk); while (in_stall);
		if (cmd <= CMD_QUERY) items_sent++;
	endtask

	// lets every pending result come back; the block is idle after that
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_status.size() != 0);
	endtask

	task automatic write_margin(input logic [MARGIN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.margin = value;
	endtask

	// start, a few vertices around a random center, commit
	task automatic build_box();
		int     cx;
		int     cz;
		int     s;
		coord_t vx;
		coord_t vz;
		cx = int'($urandom_range(0, 65535)) - 32768;
		cz = int'($urandom_range(0, 65535)) - 32768;
		s  = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(0, 1024));
		send_item(CMD_START, any_coord(), any_coord());
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 19) == 0) begin
				vx = any_coord();
				vz = any_coord();
			end else begin
				vx = clamp_coord(cx + spread(s));
				vz = clamp_coord(cz + spread(s));
			end
			send_item(CMD_VERTEX, vx, vz);
		end
		send_item(CMD_COMMIT, any_coord(), any_coord());
	endtask

	task automatic send_query();
		box_t b;
		int   x;
		int   z;
		if (sb.boxes.size() != 0 && $urandom_range(0, 2) != 0) begin
			b = sb.boxes[$urandom_range(0, sb.boxes.size() - 1)];
			x = near_edge(b.min_x, b.max_x, sb.margin);
			z = near_edge(b.min_z, b.max_z, sb.margin);
		end else begin
			x = any_coord();
			z = any_coord();
		end
		send_item(CMD_QUERY, clamp_coord(x), clamp_coord(z));
	endtask

	// mostly well-formed boxes and queries; clears are rare so the table fills up
	task automatic random_phase(input int n);
		int target;
		int roll;
		target = items_sent + n;
		while (items_sent < target) begin
			roll = $urandom_range(0, 999);
			if (roll < 4)
				send_item(CMD_CLEAR, any_coord(), any_coord());
			else if (roll < 450)
				build_box();
			else if (roll < 850)
				send_query();
			else if (roll < 900)
				send_item(CMD_COMMIT, any_coord(), any_coord());
			else if (roll < 950)
				send_item(CMD_VERTEX, any_coord(), any_coord());
			else if (roll < 980)
				send_item(CMD_START, any_coord(), any_coord());
			else
				send_item(3'($urandom_range(5, 7)), any_coord(), any_coord());
		end
	endtask

	initial begin : stimulus
		logic [MARGIN_W-1:0] margin_value;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table never hits; a bare commit stores the all-zero box
		send_item(CMD_QUERY, 16'sh0000, 16'sh0000);
		send_item(CMD_COMMIT, 16'sh1234, -16'sh1234);
		// inclusive edges with the reset margin of 8
		send_item(CMD_QUERY, 16'sh0008, 16'sh0000);
		send_item(CMD_QUERY, -16'sh0008, 16'sh0008);
		send_item(CMD_QUERY, 16'sh0009, 16'sh0000);
		send_item(CMD_QUERY, 16'sh0000, -16'sh0009);
		send_item(CMD_CLEAR, 16'sh7fff, 16'sh7fff);
		send_item(CMD_QUERY, 16'sh0000, 16'sh0000);
		// extreme vertices span the whole plane
		send_item(CMD_START, 16'sh0000, 16'sh0000);
		send_item(CMD_VERTEX, 16'sh8000, 16'sh7fff);
		send_item(CMD_VERTEX, 16'sh7fff, 16'sh8000);
		send_item(CMD_COMMIT, 16'sh0000, 16'sh0000);
		// no start in between, so the same box is stored again and keeps widening
		send_item(CMD_COMMIT, 16'sh0000, 16'sh0000);
		send_item(CMD_VERTEX, 16'sh0000, 16'sh0000);
		send_item(CMD_QUERY, 16'sh8000, 16'sh8000);
		send_item(CMD_QUERY, 16'sh7fff, 16'sh7fff);
		// unused codes only report the status
		send_item(3'd5, 16'sh7fff, 16'sh8000);
		send_item(3'd6, 16'sh5555, -16'sh5556);
		send_item(3'd7, -16'sh0001, 16'sh0000);
		// a small box after a clear, queried right at its widened corner
		send_item(CMD_CLEAR, 16'sh0000, 16'sh0000);
		send_item(CMD_START, 16'sh0000, 16'sh0000);
		send_item(CMD_VERTEX, 16'sh0100, 16'sh0100);
		send_item(CMD_VERTEX, 16'sh0200, -16'sh0180);
		send_item(CMD_COMMIT, 16'sh0000, 16'sh0000);
		send_item(CMD_QUERY, 16'sh0208, 16'sh0108);
		drain();

		// margin sweep: zero, full scale, random, reset value, small and one step
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
			0: margin_value = '0;
			1: margin_value = '1;
			3: margin_value = MARGIN_RESET;
			4: margin_value = MARGIN_W'($urandom_range(0, 64));
			5: margin_value = MARGIN_W'(1);
			default: margin_value = MARGIN_W'($urandom_range(0, 32767));
			endcase
			write_margin(margin_value);
			// one phase runs with no gaps on either side
			steady = (p == 2);
			random_phase(PHASE_ITEMS);
			drain();
		end
		steady = 1'b0;

		repeat (MAX_BOXES + 8) @(posedge clk);
		if (sb.pending_status.size() != 0) begin
			$display("%0t: %0d results never arrived, expected 0, actual %0d pending",
				$time, sb.pending_status.size(), sb.pending_status.size());
			sb.errors++;
		end
		$display("%0d commands: %0d queries with %0d hits, %0d boxes stored, %0d commits dropped",
			items_sent, sb.queries, sb.hits, sb.commits, sb.drops);
		$display("margin swept over zero, full scale, reset value and random values; %0d errors",
			sb.errors);
		if (sb.errors == 0)
			$display("aabb_table_point_collision regression: pass");
		else
			$display("aabb_table_point_collision regression: fail");
		$finish;
	end

endmodule

// File: sim.f
src/atpc_pkg.sv
src/atpc_cell.sv
src/aabb_table_point_collision.sv
bench/aabb_table_point_collision_tb.sv
